### src/sorted_priority_queue_assert.svh
// Assertion macros used by the checker file of the priority queue.
`ifndef SORTED_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("priority queue check failed");

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("priority queue check failed");

`endif

### src/spq_pkg.sv
// Package with the shared types and codes of the sorted priority queue.
`default_nettype none

package spq_pkg;

	// Width of the capacity register and of the stored fields.
	localparam int unsigned CapW  = 5;
	localparam int unsigned IdW   = 8;
	localparam int unsigned PrioW = 4;

	// Reset value of the capacity register.
	localparam logic [CapW-1:0] CapReset = 5'd16;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic {
		CTL_IDLE,
		CTL_REPORT
	} ctl_state_t;

	// Command from the controller to the datapath for one operation.
	typedef struct packed {
		logic    load;
		logic    enq;
		logic    deq;
		status_t status;
	} cmd_t;

endpackage

`default_nettype wire

### src/spq_datapath.sv
// Datapath of the priority queue: a sorted row of slots, the count and the result registers.
`default_nettype none

module spq_datapath #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire spq_pkg::cmd_t                         cmd,
	input  wire logic [spq_pkg::IdW-1:0]               request_id,
	input  wire logic [spq_pkg::PrioW-1:0]             request_priority,
	output logic [$clog2(DEPTH+1)-1:0]                 count,
	output spq_pkg::status_t                           status,
	output logic                                       out_valid,
	output logic [spq_pkg::IdW-1:0]                    out_id,
	output logic [spq_pkg::PrioW-1:0]                  out_priority
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [spq_pkg::IdW-1:0]   id_q   [DEPTH];
	logic [spq_pkg::PrioW-1:0] prio_q [DEPTH];
	logic [DEPTH-1:0]          ge;
	logic [DEPTH-1:0]          prev_ge;
	logic [CntW-1:0]           count_q;
	spq_pkg::status_t          status_q;
	logic                      out_valid_q;
	logic [spq_pkg::IdW-1:0]   out_id_q;
	logic [spq_pkg::PrioW-1:0] out_priority_q;

	// Each slot compares its own priority; held slots of equal or higher priority stay put.
	for (genvar i = 0; i < DEPTH; i++) begin : g_slot
		assign ge[i] = (count_q > CntW'(i)) && (prio_q[i] >= request_priority);

		if (i == 0) begin : g_first
			assign prev_ge[i] = 1'b1;
		end else begin : g_rest
			assign prev_ge[i] = ge[i-1];
		end

		// Enqueue inserts at the first slot that does not stay and shifts the rest back;
		// dequeue moves every slot but the last one step toward the head.
		always_ff @(posedge clk) begin
			if (cmd.enq && !ge[i]) begin
				if (prev_ge[i]) begin
					id_q[i]   <= request_id;
					prio_q[i] <= request_priority;
				end else begin
					if (i > 0) begin
						id_q[i]   <= id_q[(i > 0) ? i - 1 : 0];
						prio_q[i] <= prio_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (cmd.deq && (i < DEPTH - 1)) begin
				id_q[i]   <= id_q[(i < DEPTH - 1) ? i + 1 : i];
				prio_q[i] <= prio_q[(i < DEPTH - 1) ? i + 1 : i];
			end
		end
	end

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.enq) begin
			count_q <= count_q + CntW'(1);
		end else if (cmd.deq) begin
			count_q <= count_q - CntW'(1);
		end
	end

	// Result registers, loaded on every transfer; the head slot is returned on a dequeue.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status_q       <= cmd.status;
			out_valid_q    <= cmd.deq;
			out_id_q       <= cmd.deq ? id_q[0] : '0;
			out_priority_q <= cmd.deq ? prio_q[0] : '0;
		end
	end

	assign count        = count_q;
	assign status       = status_q;
	assign out_valid    = out_valid_q;
	assign out_id       = out_id_q;
	assign out_priority = out_priority_q;

endmodule

`default_nettype wire

### src/spq_ctrl.sv
// Controller of the priority queue: capacity register, operation decode and result strobe.
`default_nettype none

module spq_ctrl #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic                          mode,
	input  wire logic                          capacity_limit_we,
	input  wire logic [spq_pkg::CapW-1:0]      capacity_limit,
	input  wire logic [$clog2(DEPTH+1)-1:0]    count,
	output spq_pkg::cmd_t                      cmd,
	output logic                               busy,
	output logic                               done
);

	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam int unsigned CmpW = (CntW > spq_pkg::CapW) ? CntW : spq_pkg::CapW;

	logic [spq_pkg::CapW-1:0] cap_q;
	spq_pkg::ctl_state_t      state_q;
	spq_pkg::ctl_state_t      state_nxt;
	logic                     accept;
	logic                     full;
	logic                     empty;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= spq_pkg::CapReset;
		end else if (capacity_limit_we) begin
			cap_q <= capacity_limit;
		end
	end

	// Full when the count reaches the capacity or the slot row is exhausted.
	assign full  = (CmpW'(count) >= CmpW'(cap_q)) || (count >= CntW'(DEPTH));
	assign empty = (count == '0);
	assign accept = start && !busy;

	// Next state: every transfer is reported in the following cycle.
	always_comb begin
		unique case (state_q)
			spq_pkg::CTL_IDLE:   state_nxt = accept ? spq_pkg::CTL_REPORT : spq_pkg::CTL_IDLE;
			spq_pkg::CTL_REPORT: state_nxt = accept ? spq_pkg::CTL_REPORT : spq_pkg::CTL_IDLE;
			default:             state_nxt = spq_pkg::CTL_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::CTL_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Outputs: busy stays low, so a new transfer is always taken.
	always_comb begin
		busy       = 1'b0;
		done       = (state_q == spq_pkg::CTL_REPORT);
		cmd.load   = accept;
		cmd.enq    = accept && !mode && !full;
		cmd.deq    = accept && mode && !empty;
		cmd.status = spq_pkg::ST_DONE;
		if (!mode && full) begin
			cmd.status = spq_pkg::ST_FULL;
		end else if (mode && empty) begin
			cmd.status = spq_pkg::ST_EMPTY;
		end
	end

endmodule

`default_nettype wire

### src/sorted_priority_queue.sv
// Top level of the sorted priority queue.
// A transfer that is taken is reported by done in the next cycle.
// One enqueue or dequeue per cycle; busy stays low, every slot compares in parallel.
// Results are held until the next transfer loads them anew; the receiver cannot stall.
// Reset empties the queue and sets the capacity register to 16; slot contents are not cleared.
`default_nettype none

module sorted_priority_queue #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	output logic                               done,
	input  wire logic                          capacity_limit_we,
	input  wire logic [spq_pkg::CapW-1:0]      capacity_limit,
	input  wire logic                          mode,
	input  wire logic [spq_pkg::IdW-1:0]       request_id,
	input  wire logic [spq_pkg::PrioW-1:0]     request_priority,
	output logic [1:0]                         status,
	output logic                               out_valid,
	output logic [spq_pkg::IdW-1:0]            out_id,
	output logic [spq_pkg::PrioW-1:0]          out_priority,
	output logic [$clog2(DEPTH+1)-1:0]         entry_count
);

	spq_pkg::cmd_t    cmd;
	spq_pkg::status_t status_w;

	// Operation decode and result strobe.
	spq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.mode             (mode),
		.capacity_limit_we(capacity_limit_we),
		.capacity_limit   (capacity_limit),
		.count            (entry_count),
		.cmd              (cmd),
		.busy             (busy),
		.done             (done)
	);

	// Slot row and result registers.
	spq_datapath #(
		.DEPTH(DEPTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.request_id      (request_id),
		.request_priority(request_priority),
		.count           (entry_count),
		.status          (status_w),
		.out_valid       (out_valid),
		.out_id          (out_id),
		.out_priority    (out_priority)
	);

	assign status = status_w;

endmodule

`default_nettype wire

### src/spq_checker.sv
// Port-level checker of the priority queue and its bind to the top level.
`default_nettype none

`include "sorted_priority_queue_assert.svh"

module spq_checker #(
	parameter int unsigned DEPTH = 16
) (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          start,
	input wire logic                          busy,
	input wire logic                          done,
	input wire logic [1:0]                    status,
	input wire logic                          out_valid,
	input wire logic [$clog2(DEPTH+1)-1:0]    entry_count
);

	logic accept;

	assign accept = start && !busy;

	// Every transfer is reported in the next cycle, and nothing else is.
	`SPQ_ASSERT_NEXT(a_report, clk, arst_n, accept, done)
	`SPQ_ASSERT_NEXT(a_no_spurious, clk, arst_n, !accept, !done)

	// A returned entry means a successful dequeue that lowered the count by one.
	`SPQ_ASSERT_SAME(a_deq_count, clk, arst_n, done && out_valid, (status == spq_pkg::ST_DONE) && (entry_count + 1'b1 == $past(entry_count)))

	// A refused operation leaves the count alone.
	`SPQ_ASSERT_SAME(a_refused_hold, clk, arst_n, done && (status != spq_pkg::ST_DONE), entry_count == $past(entry_count))

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH(DEPTH)
) u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.status     (status),
	.out_valid  (out_valid),
	.entry_count(entry_count)
);

`default_nettype wire
